>>> rtl/ising_lattice_energy_tracker_assert.svh
// assertion macros for the ising lattice energy tracker
// used by the top level only, no dependencies
`ifndef ISING_LATTICE_ENERGY_TRACKER_ASSERT_SVH
`define ISING_LATTICE_ENERGY_TRACKER_ASSERT_SVH

// same-cycle implication
`define ILET_ASSERT_IMPL(name, clk_s, rstn_s, ante, cons) \
	name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("ilet assertion failed");

// next-cycle implication
`define ILET_ASSERT_NEXT(name, clk_s, rstn_s, ante, cons) \
	name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("ilet assertion failed");

`endif

>>> rtl/ilet_pkg.sv
// shared constants, types and codes for the ising lattice energy tracker
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ilet_pkg;

	localparam int SIDE    = 64;
	localparam int AW      = 6;                      // row and column field width
	localparam int SITES   = SIDE * SIDE;
	localparam int CW      = 8;                      // coupling
	localparam int EW      = 22;                     // running energy
	localparam int MW      = 14;                     // magnetization
	localparam int DEW     = 12;                     // flip energy change
	localparam int CNT_W   = $clog2(SIDE + 1);       // scan counter, holds SIDE
	localparam int RDIFF_W = $clog2(2 * SIDE + 1);   // unequal pairs in one row
	localparam int RPOP_W  = $clog2(SIDE + 1);       // up spins in one row
	localparam int DACC_W  = $clog2(2 * SITES + 1);
	localparam int PACC_W  = $clog2(SITES + 1);

	localparam logic signed [CW-1:0] COUPLING_RST = CW'(1);
	localparam logic [EW-1:0]        ENERGY_RST   = EW'(-2 * SITES);
	localparam logic [MW-1:0]        MAG_RST      = MW'(SITES);

	typedef logic [SIDE-1:0] row_word_t;
	typedef logic [AW-1:0]   addr_t;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_EVAL  = 2'd1,
		OP_FLIP  = 2'd2,
		OP_SCAN  = 2'd3
	} opcode_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD_MID,
		S_RD_UP,
		S_RD_DN,
		S_EXEC,
		S_WR,
		S_SCAN,
		S_DRAIN,
		S_FIN
	} state_t;

	typedef struct packed {
		logic      re;
		addr_t     raddr;
		logic      we;
		addr_t     waddr;
		row_word_t wdata;
	} mem_req_t;

	typedef struct packed {
		logic clear;
		logic feed;
	} scan_ctl_t;

endpackage

`default_nettype wire

>>> rtl/ilet_lattice_mem.sv
// row-wide spin memory, one word per lattice row, one access per cycle
// rows never written read as all spins up; depends on ilet_pkg
`timescale 1ns / 1ps
`default_nettype none

module ilet_lattice_mem (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ilet_pkg::mem_req_t    req,
	output ilet_pkg::row_word_t   rdata
);

	ilet_pkg::row_word_t                mem [ilet_pkg::SIDE];
	logic [ilet_pkg::SIDE-1:0]          row_vld_q;
	ilet_pkg::row_word_t                rd_word_q;
	logic                               rd_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
		end else if (req.we) begin
			row_vld_q[req.waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rd_word_q <= mem[req.raddr];
			rd_vld_q  <= row_vld_q[req.raddr];
		end
	end

	assign rdata = rd_vld_q ? rd_word_q : '1;

endmodule

`default_nettype wire

>>> rtl/ilet_scan_acc.sv
// recompute datapath: per-row pair and spin counts, accumulated over the scan
// turns the counts into lattice energy and magnetization; depends on ilet_pkg
`timescale 1ns / 1ps
`default_nettype none

module ilet_scan_acc (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  ilet_pkg::scan_ctl_t                   ctl,
	input  ilet_pkg::row_word_t                   cur,
	input  ilet_pkg::row_word_t                   nxt,
	input  logic signed [ilet_pkg::CW-1:0]        coupling,
	output logic [ilet_pkg::EW-1:0]               energy,
	output logic [ilet_pkg::MW-1:0]               mag
);

	function automatic logic [ilet_pkg::RPOP_W-1:0] popcount(input ilet_pkg::row_word_t w);
		logic [ilet_pkg::RPOP_W-1:0] n;
		n = '0;
		for (int i = 0; i < ilet_pkg::SIDE; i++) begin
			n = n + ilet_pkg::RPOP_W'(w[i]);
		end
		return n;
	endfunction

	ilet_pkg::row_word_t                      rot;
	logic [ilet_pkg::RDIFF_W-1:0]             diff;
	logic                                     feed_s1;
	logic [ilet_pkg::RDIFF_W-1:0]             diff_s1;
	logic [ilet_pkg::RPOP_W-1:0]              pop_s1;
	logic [ilet_pkg::DACC_W-1:0]              d_acc_q;
	logic [ilet_pkg::PACC_W-1:0]              p_acc_q;
	logic signed [ilet_pkg::DACC_W:0]         d_off;
	logic signed [ilet_pkg::CW+ilet_pkg::DACC_W:0] prod;

	// bit c of rot is the right neighbour of site c
	assign rot  = {cur[0], cur[ilet_pkg::SIDE-1:1]};
	assign diff = ilet_pkg::RDIFF_W'(popcount(cur ^ nxt)) + ilet_pkg::RDIFF_W'(popcount(cur ^ rot));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feed_s1 <= 1'b0;
		end else begin
			feed_s1 <= ctl.feed;
		end
	end

	always_ff @(posedge clk) begin
		diff_s1 <= diff;
		pop_s1  <= popcount(cur);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_acc_q <= '0;
			p_acc_q <= '0;
		end else if (ctl.clear) begin
			d_acc_q <= '0;
			p_acc_q <= '0;
		end else if (feed_s1) begin
			d_acc_q <= d_acc_q + ilet_pkg::DACC_W'(diff_s1);
			p_acc_q <= p_acc_q + ilet_pkg::PACC_W'(pop_s1);
		end
	end

	// energy = -J * (equal pairs - unequal pairs) = 2J * (unequal - sites)
	assign d_off  = $signed({1'b0, d_acc_q}) - (ilet_pkg::DACC_W + 1)'(ilet_pkg::SITES);
	assign prod   = coupling * d_off;
	assign energy = {prod[ilet_pkg::EW-2:0], 1'b0};
	assign mag    = ilet_pkg::MW'({p_acc_q, 1'b0}) - ilet_pkg::MW'(ilet_pkg::SITES);

endmodule

`default_nettype wire

>>> rtl/ising_lattice_energy_tracker.sv
// Ising lattice energy tracker, top level.
// Command channel (cmd_valid / cmd_stall) carries opcode, row, column, spin_in;
// a beat is taken when cmd_valid is high and cmd_stall is low. Result channel
// (res_valid / res_stall) returns one beat per command: energy_change,
// total_energy, magnetization and spin_out.
// The lattice sits in a row-wide memory with one access per cycle and a
// registered read, so a command reads the rows it touches one after another:
//   write          read row, write row back
//   evaluate, flip three row reads, then result
//   recompute      one read per row plus a wrap read
//                  and a short drain of the count pipeline
// cmd_stall is high from the accept until the result is in the output
// register; a result waiting there does not hold off the next command, only
// the finish of that next command.
// coupling_we writes coupling_data into the coupling register; write it only
// while idle. Reset sets all spins up, coupling 1, energy -2 * sites and
// magnetization sites; no clearing pass is needed. A stalled result holds.
// Depends on ilet_pkg, ilet_lattice_mem, ilet_scan_acc.
`timescale 1ns / 1ps
`default_nettype none

`include "ising_lattice_energy_tracker_assert.svh"

module ising_lattice_energy_tracker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                coupling_we,
	input  logic signed [ilet_pkg::CW-1:0]      coupling_data,
	input  logic                                cmd_valid,
	output logic                                cmd_stall,
	input  logic [1:0]                          opcode,
	input  logic [ilet_pkg::AW-1:0]             row,
	input  logic [ilet_pkg::AW-1:0]             column,
	input  logic                                spin_in,
	output logic                                res_valid,
	input  logic                                res_stall,
	output logic signed [ilet_pkg::DEW-1:0]     energy_change,
	output logic signed [ilet_pkg::EW-1:0]      total_energy,
	output logic signed [ilet_pkg::MW-1:0]      magnetization,
	output logic                                spin_out
);

	ilet_pkg::state_t                     state_q, state_d;
	ilet_pkg::opcode_t                    op_q;
	ilet_pkg::addr_t                      row_q, col_q;
	logic                                 spin_in_q;
	logic signed [ilet_pkg::CW-1:0]       coupling_q;
	logic [ilet_pkg::EW-1:0]              energy_q;
	logic [ilet_pkg::MW-1:0]              mag_q;
	ilet_pkg::row_word_t                  mid_q, up_q, prev_q;
	logic [ilet_pkg::CNT_W-1:0]           scan_cnt_q, didx_q;
	logic                                 dvld_q, drain_q, scan_spin_q;
	logic                                 res_valid_q;
	logic [ilet_pkg::DEW-1:0]             de_q;
	logic [ilet_pkg::EW-1:0]              etot_q;
	logic [ilet_pkg::MW-1:0]              mout_q;
	logic                                 sout_q;

	ilet_pkg::mem_req_t                   mem_req;
	ilet_pkg::scan_ctl_t                  scan_ctl;
	ilet_pkg::row_word_t                  rdata;
	logic                                 accept, out_free, load_res;
	ilet_pkg::addr_t                      row_up, row_dn, col_l, col_r, scan_addr;
	logic                                 s_mid;
	logic [2:0]                           k;
	logic signed [4:0]                    factor;
	logic signed [ilet_pkg::CW+4:0]       de_full;
	logic [ilet_pkg::DEW-1:0]             de;
	logic [ilet_pkg::EW-1:0]              energy_flip, scan_energy;
	logic [ilet_pkg::MW-1:0]              mag_flip, scan_mag;
	ilet_pkg::row_word_t                  flip_word, write_word;
	logic [ilet_pkg::DEW-1:0]             res_de_d;
	logic [ilet_pkg::EW-1:0]              res_e_d;
	logic [ilet_pkg::MW-1:0]              res_m_d;
	logic                                 res_s_d;

	ilet_lattice_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mem_req),
		.rdata  (rdata)
	);

	ilet_scan_acc u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (scan_ctl),
		.cur      (prev_q),
		.nxt      (rdata),
		.coupling (coupling_q),
		.energy   (scan_energy),
		.mag      (scan_mag)
	);

	assign cmd_stall = (state_q != ilet_pkg::S_IDLE);
	assign accept    = cmd_valid && !cmd_stall;
	assign out_free  = !res_valid_q || !res_stall;

	// periodic neighbours
	assign row_up = (row_q == '0) ? ilet_pkg::AW'(ilet_pkg::SIDE - 1) : row_q - 1'b1;
	assign row_dn = (row_q == ilet_pkg::AW'(ilet_pkg::SIDE - 1)) ? '0 : row_q + 1'b1;
	assign col_l  = (col_q == '0) ? ilet_pkg::AW'(ilet_pkg::SIDE - 1) : col_q - 1'b1;
	assign col_r  = (col_q == ilet_pkg::AW'(ilet_pkg::SIDE - 1)) ? '0 : col_q + 1'b1;
	assign scan_addr = (scan_cnt_q == ilet_pkg::CNT_W'(ilet_pkg::SIDE)) ? '0
		: scan_cnt_q[ilet_pkg::AW-1:0];

	// in S_EXEC rdata holds the row below; k counts unequal neighbours
	assign s_mid  = mid_q[col_q];
	assign k      = 3'(s_mid ^ up_q[col_q]) + 3'(s_mid ^ rdata[col_q])
		+ 3'(s_mid ^ mid_q[col_l]) + 3'(s_mid ^ mid_q[col_r]);
	assign factor = 5'd8 - {k[2:0], 2'b00};
	assign de_full = coupling_q * factor;
	assign de      = de_full[ilet_pkg::DEW-1:0];
	assign energy_flip = energy_q + {{(ilet_pkg::EW - ilet_pkg::DEW){de[ilet_pkg::DEW-1]}}, de};
	assign mag_flip    = mag_q + (s_mid ? ilet_pkg::MW'(-2) : ilet_pkg::MW'(2));

	always_comb begin
		flip_word         = mid_q;
		flip_word[col_q]  = ~s_mid;
		write_word        = rdata;
		write_word[col_q] = spin_in_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ilet_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		mem_req        = '0;
		load_res       = 1'b0;
		scan_ctl.clear = 1'b0;
		scan_ctl.feed  = dvld_q && (didx_q != '0);
		case (state_q)
			ilet_pkg::S_IDLE: begin
				if (cmd_valid) begin
					if (ilet_pkg::opcode_t'(opcode) == ilet_pkg::OP_SCAN) begin
						scan_ctl.clear = 1'b1;
						state_d        = ilet_pkg::S_SCAN;
					end else begin
						state_d = ilet_pkg::S_RD_MID;
					end
				end
			end
			ilet_pkg::S_RD_MID: begin
				mem_req.re    = 1'b1;
				mem_req.raddr = row_q;
				state_d = (op_q == ilet_pkg::OP_WRITE) ? ilet_pkg::S_WR : ilet_pkg::S_RD_UP;
			end
			ilet_pkg::S_RD_UP: begin
				mem_req.re    = 1'b1;
				mem_req.raddr = row_up;
				state_d       = ilet_pkg::S_RD_DN;
			end
			ilet_pkg::S_RD_DN: begin
				mem_req.re    = 1'b1;
				mem_req.raddr = row_dn;
				state_d       = ilet_pkg::S_EXEC;
			end
			ilet_pkg::S_EXEC: begin
				if (out_free) begin
					load_res = 1'b1;
					if (op_q == ilet_pkg::OP_FLIP) begin
						mem_req.we    = 1'b1;
						mem_req.waddr = row_q;
						mem_req.wdata = flip_word;
					end
					state_d = ilet_pkg::S_IDLE;
				end
			end
			ilet_pkg::S_WR: begin
				if (out_free) begin
					load_res      = 1'b1;
					mem_req.we    = 1'b1;
					mem_req.waddr = row_q;
					mem_req.wdata = write_word;
					state_d       = ilet_pkg::S_IDLE;
				end
			end
			ilet_pkg::S_SCAN: begin
				mem_req.re    = 1'b1;
				mem_req.raddr = scan_addr;
				if (scan_cnt_q == ilet_pkg::CNT_W'(ilet_pkg::SIDE)) begin
					state_d = ilet_pkg::S_DRAIN;
				end
			end
			ilet_pkg::S_DRAIN: begin
				if (drain_q) begin
					state_d = ilet_pkg::S_FIN;
				end
			end
			ilet_pkg::S_FIN: begin
				if (out_free) begin
					load_res = 1'b1;
					state_d  = ilet_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ilet_pkg::S_IDLE;
			end
		endcase
	end

	// result beat contents by finishing state
	always_comb begin
		res_de_d = '0;
		res_e_d  = energy_q;
		res_m_d  = mag_q;
		res_s_d  = spin_in_q;
		case (state_q)
			ilet_pkg::S_EXEC: begin
				res_de_d = de;
				if (op_q == ilet_pkg::OP_FLIP) begin
					res_e_d = energy_flip;
					res_m_d = mag_flip;
					res_s_d = ~s_mid;
				end else begin
					res_s_d = s_mid;
				end
			end
			ilet_pkg::S_FIN: begin
				res_e_d = scan_energy;
				res_m_d = scan_mag;
				res_s_d = scan_spin_q;
			end
			default: begin
				res_de_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coupling_q  <= ilet_pkg::COUPLING_RST;
			energy_q    <= ilet_pkg::ENERGY_RST;
			mag_q       <= ilet_pkg::MAG_RST;
			res_valid_q <= 1'b0;
			scan_cnt_q  <= '0;
			drain_q     <= 1'b0;
			dvld_q      <= 1'b0;
		end else begin
			if (coupling_we) begin
				coupling_q <= coupling_data;
			end
			if (load_res) begin
				energy_q    <= res_e_d;
				mag_q       <= res_m_d;
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			if (accept) begin
				scan_cnt_q <= '0;
				drain_q    <= 1'b0;
			end else if (state_q == ilet_pkg::S_SCAN) begin
				scan_cnt_q <= scan_cnt_q + 1'b1;
			end else if (state_q == ilet_pkg::S_DRAIN) begin
				drain_q <= ~drain_q;
			end
			dvld_q <= (state_q == ilet_pkg::S_SCAN);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= ilet_pkg::opcode_t'(opcode);
			row_q     <= row;
			col_q     <= column;
			spin_in_q <= spin_in;
		end
		if (state_q == ilet_pkg::S_RD_UP) begin
			mid_q <= rdata;
		end
		if (state_q == ilet_pkg::S_RD_DN) begin
			up_q <= rdata;
		end
		didx_q <= scan_cnt_q;
		if (dvld_q) begin
			prev_q <= rdata;
			if (didx_q == ilet_pkg::CNT_W'(row_q)) begin
				scan_spin_q <= rdata[col_q];
			end
		end
		if (load_res) begin
			de_q   <= res_de_d;
			etot_q <= res_e_d;
			mout_q <= res_m_d;
			sout_q <= res_s_d;
		end
	end

	assign res_valid     = res_valid_q;
	assign energy_change = de_q;
	assign total_energy  = etot_q;
	assign magnetization = mout_q;
	assign spin_out      = sout_q;

	`ILET_ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, cmd_stall)
	`ILET_ASSERT_IMPL(a_mem_one_access, clk, arst_n, mem_req.we, !mem_req.re)
	`ILET_ASSERT_IMPL(a_load_slot_free, clk, arst_n, load_res, !res_valid_q || !res_stall)
	`ILET_ASSERT_IMPL(a_feed_in_scan, clk, arst_n, scan_ctl.feed, state_q == ilet_pkg::S_SCAN || state_q == ilet_pkg::S_DRAIN)

endmodule

`default_nettype wire
